### hdl/dual_channel_ema_median3_filter_defines.svh
// Assertion macros for the dual channel EMA / median-of-3 filter.
// No dependencies; included by the top level only.
`ifndef DUAL_CHANNEL_EMA_MEDIAN3_FILTER_DEFINES_SVH
`define DUAL_CHANNEL_EMA_MEDIAN3_FILTER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define DCEMF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("filter check failed");

// next-cycle implication, disabled in reset
`define DCEMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("filter check failed");

`endif

### hdl/dcemf_pkg.sv
// Shared types and constants for the dual channel EMA / median-of-3 filter.
// No dependencies.
package dcemf_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [1:0] MODE_PASS   = 2'd0;
  localparam logic [1:0] MODE_EMA    = 2'd1;
  localparam logic [1:0] MODE_MEDIAN = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FILTER_MODE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_EMA_WEIGHT  = 2'd1;

  localparam logic [1:0] WINDOW_FULL = 2'd3;
  localparam logic [1:0] SLOT_LAST   = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          channel_is_humidity;
    logic                          sample_ok;
  } sample_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered_value;
    logic                          filtered_valid;
  } result_t;

endpackage

### hdl/dual_channel_ema_median3_filter.sv
// A result passes through the output register, and through the skid stage first if the output is stalled.
// Throughput: one sample per cycle while results are not stalled; the EMA update
// is one multiply feeding the per-channel running value register.
// A skid stage lets one input transfer complete while a result is stalled.
// Reset (rst_ni low, asynchronous) selects EMA mode, alpha 0.25, and clears
// the primed flags and window fill/slot of both channels.
`include "dual_channel_ema_median3_filter_defines.svh"

module dual_channel_ema_median3_filter #(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  dcemf_pkg::sample_t                   in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output dcemf_pkg::result_t                   out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dcemf_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [WEIGHT_FRAC_BITS-1:0]          cfg_data_i
);

  localparam int unsigned SB = dcemf_pkg::SAMPLE_BITS;
  localparam int unsigned PW = SB + WEIGHT_FRAC_BITS + 2;
  localparam logic [WEIGHT_FRAC_BITS-1:0] WEIGHT_DEFAULT =
    {2'b01, {(WEIGHT_FRAC_BITS-2){1'b0}}};
  localparam logic signed [PW-1:0] ROUND_HALF =
    $signed({{(PW-WEIGHT_FRAC_BITS){1'b0}}, 1'b1, {(WEIGHT_FRAC_BITS-1){1'b0}}});

  // configuration
  logic [1:0]                  mode_q;
  logic [WEIGHT_FRAC_BITS-1:0] weight_q;

  // per-channel filter state
  logic signed [SB-1:0] ema_q [2];
  logic [1:0]           primed_q;
  logic signed [SB-1:0] win_q [2][3];
  logic [1:0]           fill_q [2];
  logic [1:0]           slot_q [2];

  // output register and skid stage
  logic                 out_valid_q;
  dcemf_pkg::result_t   out_q;
  logic                 skid_valid_q;
  dcemf_pkg::result_t   skid_q;

  logic                 in_xfer;
  logic                 out_load;
  logic                 cfg_wr;
  logic                 ch;
  logic                 upd;
  logic signed [SB-1:0] smp;
  logic signed [SB-1:0] ema_cur;
  logic signed [SB:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_rnd;
  logic signed [SB-1:0] ema_upd;
  logic signed [SB-1:0] ema_new;
  logic [1:0]           slot;
  logic [1:0]           fill_new;
  logic [1:0]           slot_new;
  logic signed [SB-1:0] w0, w1, w2;
  logic signed [SB:0]   pair_sum;
  logic signed [SB-1:0] mn01, mx01, mid_t, med;
  dcemf_pkg::result_t   res;

  assign in_stall_o  = skid_valid_q;
  assign in_xfer     = in_valid_i && !skid_valid_q;
  assign out_load    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i &&
                       (cfg_index_i == dcemf_pkg::CFG_FILTER_MODE ||
                        cfg_index_i == dcemf_pkg::CFG_EMA_WEIGHT);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign ch  = in_data_i.channel_is_humidity;
  assign smp = in_data_i.sample_value;

  // EMA: ema + round(alpha * (sample - ema)), ties towards +inf; an unprimed channel takes the sample
  assign ema_cur  = ema_q[ch];
  assign diff     = $signed({smp[SB-1], smp}) - $signed({ema_cur[SB-1], ema_cur});
  assign prod     = diff * $signed({1'b0, weight_q});
  assign prod_rnd = prod + ROUND_HALF;
  assign ema_upd  = ema_cur + $signed(prod_rnd[WEIGHT_FRAC_BITS +: SB]);
  assign ema_new  = primed_q[ch] ? ema_upd : smp;

  // median window with the new sample in place
  assign slot     = slot_q[ch];
  assign fill_new = (fill_q[ch] == dcemf_pkg::WINDOW_FULL) ? dcemf_pkg::WINDOW_FULL
                                                           : fill_q[ch] + 2'd1;
  assign slot_new = (slot == dcemf_pkg::SLOT_LAST) ? 2'd0 : slot + 2'd1;
  assign w0 = (slot == 2'd0) ? smp : win_q[ch][0];
  assign w1 = (slot == 2'd1) ? smp : win_q[ch][1];
  assign w2 = (slot == 2'd2) ? smp : win_q[ch][2];
  assign pair_sum = $signed({w0[SB-1], w0}) + $signed({smp[SB-1], smp});
  assign mn01  = (w0 < w1) ? w0 : w1;
  assign mx01  = (w0 < w1) ? w1 : w0;
  assign mid_t = (mx01 < w2) ? mx01 : w2;
  assign med   = (mn01 > mid_t) ? mn01 : mid_t;

  always_comb begin
    res = '0;
    upd = 1'b0;
    if (in_data_i.sample_ok) begin
      case (mode_q)
        dcemf_pkg::MODE_PASS: begin
          res.filtered_value = smp;
          res.filtered_valid = 1'b1;
        end
        dcemf_pkg::MODE_EMA: begin
          res.filtered_value = ema_new;
          res.filtered_valid = 1'b1;
          upd = 1'b1;
        end
        dcemf_pkg::MODE_MEDIAN: begin
          case (fill_new)
            2'd1:    res.filtered_value = w0;
            2'd2:    res.filtered_value = pair_sum[SB:1];
            default: res.filtered_value = med;
          endcase
          res.filtered_valid = 1'b1;
          upd = 1'b1;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= dcemf_pkg::MODE_EMA;
      weight_q     <= WEIGHT_DEFAULT;
      primed_q     <= '0;
      fill_q       <= '{default: '0};
      slot_q       <= '{default: '0};
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index_i == dcemf_pkg::CFG_FILTER_MODE) begin
          mode_q <= cfg_data_i[1:0];
        end else begin
          weight_q <= (cfg_data_i == '0) ? WEIGHT_DEFAULT : cfg_data_i;
        end
        primed_q <= '0;
        fill_q   <= '{default: '0};
        slot_q   <= '{default: '0};
      end else if (in_xfer && upd) begin
        if (mode_q == dcemf_pkg::MODE_EMA) begin
          primed_q[ch] <= 1'b1;
        end else begin
          fill_q[ch] <= fill_new;
          slot_q[ch] <= slot_new;
        end
      end
      if (out_load) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_xfer;
        end
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload and filter storage
  always_ff @(posedge clk_i) begin
    if (in_xfer && upd) begin
      if (mode_q == dcemf_pkg::MODE_EMA) begin
        ema_q[ch] <= ema_new;
      end else begin
        win_q[ch][slot] <= smp;
      end
    end
    if (out_load) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (in_xfer) begin
      skid_q <= res;
    end
  end

  `DCEMF_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q)
  `DCEMF_ASSERT_NOW(a_slot_tracks_fill_t, fill_q[0] != dcemf_pkg::WINDOW_FULL,
                    slot_q[0] == fill_q[0])
  `DCEMF_ASSERT_NOW(a_slot_tracks_fill_h, fill_q[1] != dcemf_pkg::WINDOW_FULL,
                    slot_q[1] == fill_q[1])
  `DCEMF_ASSERT_NEXT(a_cfg_clears, cfg_wr,
                     primed_q == 2'b00 && fill_q[0] == 2'd0 && fill_q[1] == 2'd0)
  `DCEMF_ASSERT_NEXT(a_xfer_offered, in_xfer && out_load && !skid_valid_q, out_valid_q)

endmodule

### bench/dual_channel_ema_median3_filter_checker.sv
// Result checker for the dual channel EMA / median-of-3 filter.
// Watches the sample, result and register write channels and predicts each result.
// Depends on dcemf_pkg.
module dual_channel_ema_median3_filter_checker
  import dcemf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  sample_t                 in_data_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  result_t                 out_data_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  output int                      mismatch_count_o,
  output int                      pending_o
);

  localparam int          WEIGHT_BITS    = 16;
  localparam logic [15:0] WEIGHT_DEFAULT = 16'h4000;

  logic [1:0]                    mode_q;
  logic [15:0]                   weight_q;
  logic signed [SAMPLE_BITS-1:0] ema_acc [2];
  logic                          ema_seeded [2];
  logic signed [SAMPLE_BITS-1:0] window [2][3];
  logic [1:0]                    fill [2];
  logic [1:0]                    slot [2];
  result_t                       predicted_results [$];
  int                            mismatches = 0;

  task automatic clear_filters();
    for (int c = 0; c < 2; c++) begin
      ema_seeded[c] = 1'b0;
      fill[c]       = '0;
      slot[c]       = '0;
    end
  endtask

  function automatic result_t filter_sample(input sample_t s);
    result_t                       r;
    int                            c;
    longint                        prod;
    logic signed [SAMPLE_BITS-1:0] a, b, x, lo, hi, mid;
    r = '0;
    c = int'(s.channel_is_humidity);
    if (!s.sample_ok) return r;
    case (mode_q)
      MODE_PASS: begin
        r.filtered_value = s.sample_value;
        r.filtered_valid = 1'b1;
      end
      MODE_EMA: begin
        if (!ema_seeded[c]) begin
          ema_acc[c]    = s.sample_value;
          ema_seeded[c] = 1'b1;
        end else begin
          prod = (longint'($signed(s.sample_value)) - longint'(ema_acc[c]))
                 * longint'(weight_q);
          prod = prod + (longint'(1) << (WEIGHT_BITS - 1));
          ema_acc[c] = SAMPLE_BITS'(longint'(ema_acc[c]) + (prod >>> WEIGHT_BITS));
        end
        r.filtered_value = ema_acc[c];
        r.filtered_valid = 1'b1;
      end
      MODE_MEDIAN: begin
        window[c][slot[c]] = s.sample_value;
        slot[c] = (slot[c] == SLOT_LAST) ? 2'd0 : slot[c] + 2'd1;
        if (fill[c] != WINDOW_FULL) fill[c] = fill[c] + 2'd1;
        a = window[c][0];
        b = window[c][1];
        x = window[c][2];
        if (fill[c] == 2'd1) begin
          r.filtered_value = a;
        end else if (fill[c] == 2'd2) begin
          r.filtered_value = SAMPLE_BITS'((longint'(a) + longint'(b)) >>> 1);
        end else begin
          lo  = (a < b) ? a : b;
          hi  = (a < b) ? b : a;
          mid = (hi < x) ? hi : x;
          r.filtered_value = (lo > mid) ? lo : mid;
        end
        r.filtered_valid = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      mode_q   = MODE_EMA;
      weight_q = WEIGHT_DEFAULT;
      for (int c = 0; c < 2; c++) begin
        ema_acc[c] = '0;
        for (int k = 0; k < 3; k++) window[c][k] = '0;
      end
      clear_filters();
      predicted_results.delete();
      mismatch_count_o <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_FILTER_MODE) begin
          mode_q = cfg_data_i[1:0];
          clear_filters();
        end else if (cfg_index_i == CFG_EMA_WEIGHT) begin
          weight_q = (cfg_data_i == '0) ? WEIGHT_DEFAULT : cfg_data_i;
          clear_filters();
        end
      end
      if (in_valid_i && !in_stall_i) predicted_results.push_back(filter_sample(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (predicted_results.size() == 0) begin
          $error("unexpected result transfer: filtered_value %0d, filtered_valid %0b",
                 $signed(out_data_i.filtered_value), out_data_i.filtered_valid);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          if (out_data_i.filtered_value !== want.filtered_value) begin
            $error("filtered_value: expected %0d, got %0d",
                   $signed(want.filtered_value), $signed(out_data_i.filtered_value));
            mismatches++;
          end
          if (out_data_i.filtered_valid !== want.filtered_valid) begin
            $error("filtered_valid: expected %0b, got %0b",
                   want.filtered_valid, out_data_i.filtered_valid);
            mismatches++;
          end
        end
      end
      mismatch_count_o <= mismatches;
      pending_o        <= predicted_results.size();
    end
  end

endmodule

### bench/dual_channel_ema_median3_filter_tb.sv
// Testbench top for the dual channel EMA / median-of-3 filter: clock, reset,
// sample and register write stimulus, receiver stalls and the verdict.
// Depends on dcemf_pkg, the filter and dual_channel_ema_median3_filter_checker.
module dual_channel_ema_median3_filter_tb;
  import dcemf_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int PHASES           = 16;
  localparam int PHASE_ITEMS      = 94;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int HOLD_ITEMS       = 30;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [1:0]              MODE_SPARE  = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'sh7fffff;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'sh800000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_stall_o;
  sample_t                 in_data_i   = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  result_t                 out_data_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i = '0;
  logic [15:0]             cfg_data_i  = '0;

  int mismatch_count;
  int pending;
  int cycle_count     = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  logic signed [SAMPLE_BITS-1:0] level [2] = '{24'sh001900, 24'sh003200};

  dual_channel_ema_median3_filter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  dual_channel_ema_median3_filter_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .in_data_i        (in_data_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_data_i       (out_data_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk_i) begin
    if (holds_requested != holds_served) begin
      holds_served++;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("dual_channel_ema_median3_filter_tb: done, errors");
    $finish;
  end

  function automatic sample_t make_sample(input logic signed [SAMPLE_BITS-1:0] v,
                                          input logic hum, input logic ok);
    sample_t s;
    s.sample_value        = v;
    s.channel_is_humidity = hum;
    s.sample_ok           = ok;
    return s;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      c;
    c = $urandom_range(1);
    s.channel_is_humidity = c[0];
    s.sample_ok           = ($urandom_range(15) != 0);
    case ($urandom_range(9))
      0: s.sample_value = SAMPLE_BITS'($urandom);
      1: begin
        case ($urandom_range(3))
          0: s.sample_value = SAMPLE_MAX;
          1: s.sample_value = SAMPLE_MIN;
          2: s.sample_value = '0;
          default: s.sample_value = -24'sd1;
        endcase
      end
      2: begin
        level[c] = SAMPLE_BITS'($urandom);
        s.sample_value = level[c];
      end
      default: s.sample_value = level[c] + SAMPLE_BITS'($urandom_range(1023)) - 24'sd512;
    endcase
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure_phase();
    logic [1:0]  mode;
    logic [15:0] weight;
    int          pick;
    if ($urandom_range(7) == 0) begin
      // no clear: filter state carries over into the next phase
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, 16'($urandom));
      return;
    end
    pick = $urandom_range(15);
    if (pick == 0) mode = MODE_SPARE;
    else if (pick < 5) mode = MODE_PASS;
    else if (pick < 11) mode = MODE_EMA;
    else mode = MODE_MEDIAN;
    case ($urandom_range(5))
      0: weight = 16'h0000;
      1: weight = 16'h0001;
      2: weight = 16'hffff;
      default: weight = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(3))
      0: write_reg(CFG_FILTER_MODE, {14'($urandom), mode});
      1: begin
        write_reg(CFG_EMA_WEIGHT, weight);
        write_reg(CFG_FILTER_MODE, {14'd0, mode});
      end
      default: begin
        write_reg(CFG_FILTER_MODE, {14'd0, mode});
        write_reg(CFG_EMA_WEIGHT, weight);
      end
    endcase
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // EMA with reset weight, seeding per channel, ignored sample
    send_sample(make_sample(SAMPLE_MAX, 1'b0, 1'b1));
    send_sample(make_sample(SAMPLE_MIN, 1'b0, 1'b1));
    send_sample(make_sample(24'sd0, 1'b1, 1'b1));
    send_sample(make_sample(-24'sd1, 1'b1, 1'b1));
    send_sample(make_sample(SAMPLE_MAX, 1'b1, 1'b0));
    send_sample(make_sample(SAMPLE_MIN, 1'b0, 1'b1));
    drain();
    write_reg(CFG_EMA_WEIGHT, 16'hffff);
    send_sample(make_sample(SAMPLE_MIN, 1'b0, 1'b1));
    send_sample(make_sample(SAMPLE_MAX, 1'b0, 1'b1));
    drain();
    // zero weight falls back to a quarter; rounding ties
    write_reg(CFG_EMA_WEIGHT, 16'h0000);
    send_sample(make_sample(24'sd100, 1'b1, 1'b1));
    send_sample(make_sample(24'sd102, 1'b1, 1'b1));
    send_sample(make_sample(24'sd99, 1'b1, 1'b1));
    drain();
    write_reg(CFG_EMA_WEIGHT, 16'h0001);
    write_reg(CFG_FILTER_MODE, {14'd0, MODE_PASS});
    send_sample(make_sample(SAMPLE_MAX, 1'b0, 1'b1));
    send_sample(make_sample(SAMPLE_MIN, 1'b1, 1'b1));
    send_sample(make_sample(24'sd5, 1'b0, 1'b0));
    drain();
    // median: partial fill averages, full ring, wrap
    write_reg(CFG_FILTER_MODE, {14'd0, MODE_MEDIAN});
    send_sample(make_sample(SAMPLE_MAX, 1'b0, 1'b1));
    send_sample(make_sample(SAMPLE_MIN, 1'b1, 1'b1));
    send_sample(make_sample(SAMPLE_MIN, 1'b0, 1'b1));
    send_sample(make_sample(-24'sd2, 1'b1, 1'b1));
    send_sample(make_sample(24'sd7, 1'b0, 1'b0));
    send_sample(make_sample(24'sd3, 1'b0, 1'b1));
    send_sample(make_sample(24'sd3, 1'b0, 1'b1));
    drain();
    write_reg(CFG_SPARE_A, 16'hffff);
    send_sample(make_sample(-24'sd5, 1'b0, 1'b1));
    drain();
    write_reg(CFG_FILTER_MODE, {14'd0, MODE_SPARE});
    send_sample(make_sample(24'sd9, 1'b0, 1'b1));
    send_sample(make_sample(24'sd9, 1'b1, 1'b0));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct <= 0;  end
        1: begin send_idle_pct = 83; stall_pct <= 0;  end
        2: begin send_idle_pct = 0;  stall_pct <= 83; end
        default: begin send_idle_pct = 20; stall_pct <= 20; end
      endcase
      configure_phase();
      repeat (PHASE_ITEMS) send_sample(random_sample());
      drain();
      if (p == 6) begin
        // long receiver hold-off while samples keep coming
        send_idle_pct = 0;
        stall_pct <= 0;
        holds_requested <= holds_requested + 1;
        repeat (HOLD_ITEMS) send_sample(random_sample());
        drain();
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("dual_channel_ema_median3_filter_tb: done, clean");
    end else begin
      $display("dual_channel_ema_median3_filter_tb: done, errors");
    end
    $finish;
  end

endmodule
